// ===== hw/rtl/dlts_pkg.sv =====
`timescale 1ns / 1ps

package dlts_pkg;

  // Fixed field widths
  localparam int unsigned TASK_W     = 8;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned TCNT_W     = 5;
  localparam int unsigned PEND_W     = 8;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SLOT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

  // Read address select
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_ZERO   = 3'd1;
  localparam logic [2:0] RD_PTR_UP = 3'd2;
  localparam logic [2:0] RD_PTR_DN = 3'd3;
  localparam logic [2:0] RD_CNT_M1 = 3'd4;
  localparam logic [2:0] RD_POS    = 3'd5;

  // Write select
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_TICK = 3'd1;
  localparam logic [2:0] WR_UP   = 3'd2;
  localparam logic [2:0] WR_NEW  = 3'd3;
  localparam logic [2:0] WR_DN   = 3'd4;

  // Position register source
  localparam logic [2:0] POS_KEEP = 3'd0;
  localparam logic [2:0] POS_ZERO = 3'd1;
  localparam logic [2:0] POS_SLOT = 3'd2;
  localparam logic [2:0] POS_PTR  = 3'd3;
  localparam logic [2:0] POS_CNT  = 3'd4;

  // One list entry as stored in the table
  typedef struct packed {
    logic [DELTA_W-1:0] period;
    logic [DELTA_W-1:0] delta;
    logic [TASK_W-1:0]  task_id;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;
    logic [2:0]       rd_sel;
    logic [2:0]       wr_sel;
    logic [2:0]       pos_sel;
    logic             dly_sub;
    logic             hold_ld;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             readd;
    logic             res_run;
    logic [ERR_W-1:0] err_set;
    logic             out_ld;
  } dlts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cnt_zero;
    logic              cnt_full;
    logic              pend_zero;
    logic              slot_bad;
    logic              delta_le;
    logic              ptr_last;
    logic              ptr_at_pos;
    logic              hold_per_zero;
  } dlts_stat_t;

endpackage

// ===== hw/rtl/delta_list_task_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Per item: a tick on a non-empty list counts down the head entry's delta, or counts a pending
// run once it is zero; an add scans for its place and, when it lands inside the list, first
// moves the later entries up one slot; a delete or dispatch moves the later entries down one
// slot; a re-adding dispatch runs both walks. The single-port table walk moves one entry a cycle.
// One item at a time: the next beat can be taken in the cycle after the result is registered, even
// while it waits. Reset (rst_n low, synchronous) empties the list; table data is kept.
module delta_list_task_scheduler_unit
  import dlts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] task_ident, [23:8] start_delay,
                                            // [39:24] repeat_period, [43:40] slot_index
  input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] run_valid, [8:1] run_task,
                                            // [10:9] error_code, [15:11] task_count
);

  dlts_cmd_t  cmd;
  dlts_stat_t stat;

  dlts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dlts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hw/rtl/dlts_dpath.sv =====
`timescale 1ns / 1ps

module dlts_dpath
  import dlts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // task_ident, start_delay, repeat_period, slot_index
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic [OUT_DATA_W-1:0] out_tdata,  // run_valid, run_task, error_code, task_count
  input  dlts_cmd_t             cmd,
  output dlts_stat_t            stat
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  // Task table
  entry_t mem [MAX_TASKS];
  entry_t rd_q_r;
  logic   rd_en;
  logic   [IW-1:0] rd_addr;
  logic   wr_en;
  logic   [IW-1:0] wr_addr;
  entry_t wr_data;

  // Item and walk registers
  logic [KIND_W-1:0]  kind_r;
  logic [TASK_W-1:0]  id_r;
  logic [DELTA_W-1:0] dly_r;
  logic [DELTA_W-1:0] per_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [IW-1:0]      ptr_r;
  logic [CW-1:0]      pos_r;
  entry_t             hold_r;

  // List state
  logic [CW-1:0]     cnt_r;
  logic [PEND_W-1:0] pend_r;

  // Result
  logic                  res_run_r;
  logic [TASK_W-1:0]     res_task_r;
  logic [ERR_W-1:0]      res_err_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [DELTA_W:0]   merge_sum;
  logic [DELTA_W-1:0] merged;
  logic               ptr_at_pos;
  logic               ptr_after_pos;

  assign ptr_at_pos    = (CW'(ptr_r) == pos_r);
  assign ptr_after_pos = (CW'(ptr_r) == pos_r + CW'(1));
  assign merge_sum     = {1'b0, rd_q_r.delta} + {1'b0, hold_r.delta};
  assign merged        = merge_sum[DELTA_W] ? '1 : merge_sum[DELTA_W-1:0];

  // Read address decode
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (cmd.rd_sel)
      RD_ZERO:   rd_addr = '0;
      RD_PTR_UP: rd_addr = ptr_r + IW'(1);
      RD_PTR_DN: rd_addr = ptr_r - IW'(1);
      RD_CNT_M1: rd_addr = IW'(cnt_r - CW'(1));
      RD_POS:    rd_addr = IW'(pos_r);
      default:   rd_en   = 1'b0;
    endcase
  end

  // Write decode
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = rd_q_r;
    unique case (cmd.wr_sel)
      WR_TICK: begin
        wr_addr       = '0;
        wr_data.delta = rd_q_r.delta - DELTA_W'(1);
        wr_en         = (rd_q_r.delta != '0);
      end
      WR_UP: begin
        wr_addr = ptr_r + IW'(1);
        if (ptr_at_pos) begin
          wr_data.delta = rd_q_r.delta - dly_r;
        end
      end
      WR_NEW: begin
        wr_addr         = IW'(pos_r);
        wr_data.period  = per_r;
        wr_data.delta   = dly_r;
        wr_data.task_id = id_r;
      end
      WR_DN: begin
        wr_addr = ptr_r - IW'(1);
        if (ptr_after_pos) begin
          wr_data.delta = merged;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
      ptr_r  <= rd_addr;
    end
  end

  // Item fields, running delay, position and held entry
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser;
      id_r   <= in_tdata[7:0];
      dly_r  <= in_tdata[23:8];
      per_r  <= in_tdata[39:24];
      slot_r <= in_tdata[43:40];
    end else if (cmd.readd) begin
      id_r  <= hold_r.task_id;
      dly_r <= hold_r.period;
      per_r <= hold_r.period;
    end else if (cmd.dly_sub) begin
      dly_r <= dly_r - rd_q_r.delta;
    end
    case (cmd.pos_sel)
      POS_ZERO: pos_r <= '0;
      POS_SLOT: pos_r <= CW'(slot_r);
      POS_PTR:  pos_r <= CW'(ptr_r);
      POS_CNT:  pos_r <= cnt_r;
      default:  pos_r <= pos_r;
    endcase
    if (cmd.hold_ld) begin
      hold_r <= rd_q_r;
    end
  end

  // Entry count and pending runs of the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.cnt_dec && pos_r == '0) begin
        pend_r <= '0;
      end else if (cmd.wr_sel == WR_TICK && rd_q_r.delta == '0 && pend_r != '1) begin
        pend_r <= pend_r + PEND_W'(1);
      end
    end
  end

  // Result fields and output beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_run_r  <= 1'b0;
      res_task_r <= '0;
      res_err_r  <= ERR_NONE;
    end else begin
      if (cmd.res_run) begin
        res_run_r  <= 1'b1;
        res_task_r <= hold_r.task_id;
      end
      if (cmd.err_set != ERR_NONE) begin
        res_err_r <= cmd.err_set;
      end
    end
    if (cmd.out_ld) begin
      out_data_r <= {TCNT_W'(cnt_r), res_err_r, res_task_r, res_run_r};
    end
  end

  assign out_tdata = out_data_r;

  // Status
  always_comb begin
    stat.kind          = kind_r;
    stat.cnt_zero      = (cnt_r == '0);
    stat.cnt_full      = (cnt_r == CW'(MAX_TASKS));
    stat.pend_zero     = (pend_r == '0);
    stat.slot_bad      = (32'(slot_r) >= 32'(cnt_r));
    stat.delta_le      = (rd_q_r.delta <= dly_r);
    stat.ptr_last      = (CW'(ptr_r) + CW'(1) == cnt_r);
    stat.ptr_at_pos    = ptr_at_pos;
    stat.hold_per_zero = (hold_r.period == '0);
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_TASKS))
    else $error("entry count beyond table depth");
  a_pend_head: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != '0 |-> cnt_r != '0)
    else $error("pending runs without a head entry");
  a_dn_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel == WR_DN |-> ptr_r != '0)
    else $error("shift-down write below slot zero");
`endif

endmodule

// ===== hw/rtl/dlts_ctrl.sv =====
`timescale 1ns / 1ps

module dlts_ctrl
  import dlts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dlts_stat_t stat,
  output dlts_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_INS0  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SH0   = 4'd5;
  localparam logic [3:0] S_SH    = 4'd6;
  localparam logic [3:0] S_NEW   = 4'd7;
  localparam logic [3:0] S_RM0   = 4'd8;
  localparam logic [3:0] S_RM1   = 4'd9;
  localparam logic [3:0] S_RMSH  = 4'd10;
  localparam logic [3:0] S_RMEND = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;

  // Take no beat while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  // Sequence one item
  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_NONE;
    cmd.wr_sel  = WR_NONE;
    cmd.pos_sel = POS_KEEP;
    cmd.err_set = ERR_NONE;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.kind)
          KIND_TICK: begin
            if (stat.cnt_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.rd_sel = RD_ZERO;
              state_nxt  = S_TICK;
            end
          end
          KIND_ADD: state_nxt = S_INS0;
          KIND_DISPATCH: begin
            if (!stat.pend_zero && !stat.cnt_zero) begin
              cmd.pos_sel = POS_ZERO;
              state_nxt   = S_RM0;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            if (stat.slot_bad) begin
              cmd.err_set = ERR_BAD_SLOT;
              state_nxt   = S_DONE;
            end else begin
              cmd.pos_sel = POS_SLOT;
              state_nxt   = S_RM0;
            end
          end
        endcase
      end
      S_TICK: begin
        cmd.wr_sel = WR_TICK;
        state_nxt  = S_DONE;
      end
      S_INS0: begin
        if (stat.cnt_full) begin
          cmd.err_set = ERR_FULL;
          state_nxt   = S_DONE;
        end else if (stat.cnt_zero) begin
          cmd.pos_sel = POS_ZERO;
          state_nxt   = S_NEW;
        end else begin
          cmd.rd_sel = RD_ZERO;
          state_nxt  = S_SCAN;
        end
      end
      // Walk while the entry expires no later than the new one
      S_SCAN: begin
        if (stat.delta_le) begin
          cmd.dly_sub = 1'b1;
          if (stat.ptr_last) begin
            cmd.pos_sel = POS_CNT;
            state_nxt   = S_NEW;
          end else begin
            cmd.rd_sel = RD_PTR_UP;
          end
        end else begin
          cmd.pos_sel = POS_PTR;
          state_nxt   = S_SH0;
        end
      end
      S_SH0: begin
        cmd.rd_sel = RD_CNT_M1;
        state_nxt  = S_SH;
      end
      // Move entries up one slot, tail first
      S_SH: begin
        cmd.wr_sel = WR_UP;
        if (stat.ptr_at_pos) begin
          state_nxt = S_NEW;
        end else begin
          cmd.rd_sel = RD_PTR_DN;
        end
      end
      S_NEW: begin
        cmd.wr_sel  = WR_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_RM0: begin
        cmd.rd_sel = RD_POS;
        state_nxt  = S_RM1;
      end
      S_RM1: begin
        cmd.hold_ld = 1'b1;
        if (stat.ptr_last) begin
          state_nxt = S_RMEND;
        end else begin
          cmd.rd_sel = RD_PTR_UP;
          state_nxt  = S_RMSH;
        end
      end
      // Move entries down one slot, head side first
      S_RMSH: begin
        cmd.wr_sel = WR_DN;
        if (stat.ptr_last) begin
          state_nxt = S_RMEND;
        end else begin
          cmd.rd_sel = RD_PTR_UP;
        end
      end
      S_RMEND: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_DONE;
        if (stat.kind == KIND_DISPATCH) begin
          cmd.res_run = 1'b1;
          if (!stat.hold_per_zero) begin
            cmd.readd = 1'b1;
            state_nxt = S_INS0;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output beat valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_ld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_DEC)
    else $error("accepted beat not decoded next cycle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_vld_r || out_tready))
    else $error("result overwrites a waiting beat");
  a_new_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEW |-> !stat.cnt_full)
    else $error("insert into a full table");
`endif

endmodule
